// File: rtl/core/mi3_pkg.sv
// mi3_pkg: shared constants, types and index tables for the 3x3 matrix inverse core.
// No dependencies; every other file of the core imports it.
`timescale 1ns / 1ps

package mi3_pkg;

    localparam int ELEM_WIDTH_DEF  = 16;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int WIDE_W          = 64;  // wrapping datapath for cofactors and determinant
    localparam int DET_W           = 52;
    localparam int INV_W           = 32;
    localparam int N_ELEM          = 9;
    localparam int QBITS           = 31;  // quotient bits: 3 integer + 28 fraction
    localparam int REM_W           = WIDE_W + 3;
    localparam int DIV_W           = WIDE_W + 2;

    typedef logic [WIDE_W-1:0] wide_t;

    typedef struct packed {
        wide_t [N_ELEM-1:0] cof;
        wide_t              det;
    } front_item_t;

    // cof[k] = e[A1]*e[A2] - e[B1]*e[B2], elements in row-major order
    localparam int COF_A1 [N_ELEM] = '{4, 7, 1, 6, 0, 3, 3, 6, 0};
    localparam int COF_A2 [N_ELEM] = '{8, 2, 5, 5, 8, 2, 7, 1, 4};
    localparam int COF_B1 [N_ELEM] = '{7, 1, 4, 3, 6, 0, 6, 0, 3};
    localparam int COF_B2 [N_ELEM] = '{5, 8, 2, 8, 2, 5, 4, 7, 1};
    // det = a00*cof0 + a01*cof3 + a02*cof6
    localparam int DET_COF [3] = '{0, 3, 6};

    localparam logic [INV_W-1:0] INV_MAX = {1'b0, {(INV_W-1){1'b1}}};
    localparam logic [INV_W-1:0] INV_MIN = {1'b1, {(INV_W-1){1'b0}}};

endpackage

// File: rtl/core/mi3_if.sv
// mi3_in_if / mi3_out_if: valid/ready channels carrying a matrix and its inverse.
// Depends on mi3_pkg.
`timescale 1ns / 1ps

interface mi3_in_if import mi3_pkg::*; #(
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [ELEM_WIDTH-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;

    modport source (output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                    input ready);
    modport sink   (input valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                    output ready);
endinterface

interface mi3_out_if import mi3_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic signed [INV_W-1:0] inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22;
    logic signed [DET_W-1:0] determinant;
    logic                    singular;

    modport source (output valid, inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21,
                    inv22, determinant, singular, input ready);
    modport sink   (input valid, inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21,
                    inv22, determinant, singular, output ready);
endinterface

// File: rtl/core/mi3_front.sv
// mi3_front: accepts matrices, forms the nine cofactors and the determinant in four stages.
// Depends on mi3_pkg and mi3_in_if.
`timescale 1ns / 1ps

module mi3_front import mi3_pkg::*; #(
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    mi3_in_if.sink      in_ch,
    output logic        out_valid,
    input  logic        out_ready,
    output front_item_t out_item
);

    localparam int PROD_W = 2 * ELEM_WIDTH;

    logic signed [ELEM_WIDTH-1:0] elem [N_ELEM];
    logic                         adv;

    logic                     v1_reg, v2_reg, v3_reg, v4_reg;
    logic signed [PROD_W-1:0] pa_reg [N_ELEM];
    logic signed [PROD_W-1:0] pb_reg [N_ELEM];
    wide_t                    row1_reg [3];
    wide_t                    row2_reg [3];
    wide_t                    cof2_reg [N_ELEM];
    wide_t                    cof3_reg [N_ELEM];
    wide_t                    mll_reg [3];
    logic [31:0]              mlh_reg [3];
    logic [31:0]              mhl_reg [3];
    front_item_t              item4_reg;

    wide_t cof_next [N_ELEM];
    wide_t mll_next [3];
    logic [31:0] mlh_next [3];
    logic [31:0] mhl_next [3];
    wide_t det_next;

    assign elem[0] = in_ch.a00;
    assign elem[1] = in_ch.a01;
    assign elem[2] = in_ch.a02;
    assign elem[3] = in_ch.a10;
    assign elem[4] = in_ch.a11;
    assign elem[5] = in_ch.a12;
    assign elem[6] = in_ch.a20;
    assign elem[7] = in_ch.a21;
    assign elem[8] = in_ch.a22;

    // whole pipe moves together; it only holds when the last stage is blocked
    assign adv         = !v4_reg || out_ready;
    assign in_ch.ready = adv;
    assign out_valid   = v4_reg;
    assign out_item    = item4_reg;

    always_comb
    begin
        for (int k = 0; k < N_ELEM; k++)
        begin
            cof_next[k] = WIDE_W'(pa_reg[k]) - WIDE_W'(pb_reg[k]);
        end
        for (int j = 0; j < 3; j++)
        begin
            // product mod 2^64 from three 32x32 partial products
            mll_next[j] = row2_reg[j][31:0] * cof2_reg[DET_COF[j]][31:0];
            mlh_next[j] = row2_reg[j][31:0] * cof2_reg[DET_COF[j]][63:32];
            mhl_next[j] = row2_reg[j][63:32] * cof2_reg[DET_COF[j]][31:0];
        end
        det_next = '0;
        for (int j = 0; j < 3; j++)
        begin
            det_next = det_next + mll_reg[j] + {mlh_reg[j] + mhl_reg[j], 32'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_ch.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < N_ELEM; k++)
            begin
                pa_reg[k]   <= elem[COF_A1[k]] * elem[COF_A2[k]];
                pb_reg[k]   <= elem[COF_B1[k]] * elem[COF_B2[k]];
                cof2_reg[k] <= cof_next[k];
                cof3_reg[k] <= cof2_reg[k];
                item4_reg.cof[k] <= cof3_reg[k];
            end
            for (int j = 0; j < 3; j++)
            begin
                row1_reg[j] <= WIDE_W'(elem[j]);
                row2_reg[j] <= row1_reg[j];
                mll_reg[j]  <= mll_next[j];
                mlh_reg[j]  <= mlh_next[j];
                mhl_reg[j]  <= mhl_next[j];
            end
            item4_reg.det <= det_next;
        end
    end

endmodule

// File: rtl/core/mi3_queue.sv
// mi3_queue: small register FIFO between the front and back halves.
// Depends on mi3_pkg.
`timescale 1ns / 1ps

module mi3_queue import mi3_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  front_item_t in_item,
    output logic        out_valid,
    input  logic        out_ready,
    output front_item_t out_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    front_item_t      mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push, pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_item  = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// File: rtl/core/mi3_back.sv
// mi3_back: magnitudes, saturation check, nine 31-stage restoring dividers, output register.
// Depends on mi3_pkg and mi3_out_if.
`timescale 1ns / 1ps

module mi3_back import mi3_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  front_item_t in_item,
    mi3_out_if.source   out_ch
);

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [DIV_W-1:0] dvs;
        logic [QBITS-1:0] quo;
        logic             neg;
        logic             sat;
    } lane_t;

    logic adv;

    // magnitude stage
    logic                    v0_reg;
    wide_t                   amag_reg [N_ELEM];
    logic                    neg0_reg [N_ELEM];
    wide_t                   dmag_reg;
    logic                    sing0_reg;
    logic [DET_W-1:0]        det0_reg;

    // divider stages: index 0 is the initialized state, QBITS is done
    logic                    vs_reg   [QBITS+1];
    logic                    sing_reg [QBITS+1];
    logic [DET_W-1:0]        det_reg  [QBITS+1];
    lane_t                   ln_reg   [QBITS+1][N_ELEM];
    lane_t                   ln_next  [QBITS+1][N_ELEM];

    logic                    out_valid_reg;
    logic [INV_W-1:0]        inv_reg [N_ELEM];
    logic [DET_W-1:0]        det_out_reg;
    logic                    sing_out_reg;
    logic [INV_W-1:0]        inv_next [N_ELEM];

    assign adv      = !out_valid_reg || out_ch.ready;
    assign in_ready = adv;

    always_comb
    begin
        for (int k = 0; k < N_ELEM; k++)
        begin
            ln_next[0][k].rem = REM_W'(amag_reg[k]);
            ln_next[0][k].dvs = {dmag_reg, 2'b00};
            ln_next[0][k].quo = '0;
            ln_next[0][k].neg = neg0_reg[k];
            // quotient of 8 or more does not fit Q16.16
            ln_next[0][k].sat = {3'b000, amag_reg[k]} >= {dmag_reg, 3'b000};
        end
        for (int s = 1; s <= QBITS; s++)
        begin
            for (int k = 0; k < N_ELEM; k++)
            begin
                ln_next[s][k] = ln_reg[s-1][k];
                if (ln_reg[s-1][k].rem >= REM_W'(ln_reg[s-1][k].dvs))
                begin
                    ln_next[s][k].rem = (ln_reg[s-1][k].rem - REM_W'(ln_reg[s-1][k].dvs)) << 1;
                    ln_next[s][k].quo = {ln_reg[s-1][k].quo[QBITS-2:0], 1'b1};
                end
                else
                begin
                    ln_next[s][k].rem = ln_reg[s-1][k].rem << 1;
                    ln_next[s][k].quo = {ln_reg[s-1][k].quo[QBITS-2:0], 1'b0};
                end
            end
        end
        for (int k = 0; k < N_ELEM; k++)
        begin
            if (sing_reg[QBITS])
            begin
                inv_next[k] = '0;
            end
            else if (ln_reg[QBITS][k].sat)
            begin
                inv_next[k] = ln_reg[QBITS][k].neg ? INV_MIN : INV_MAX;
            end
            else if (ln_reg[QBITS][k].neg)
            begin
                inv_next[k] = '0 - {1'b0, ln_reg[QBITS][k].quo};
            end
            else
            begin
                inv_next[k] = {1'b0, ln_reg[QBITS][k].quo};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int s = 0; s <= QBITS; s++)
            begin
                vs_reg[s] <= 1'b0;
            end
        end
        else if (adv)
        begin
            v0_reg    <= in_valid;
            vs_reg[0] <= v0_reg;
            for (int s = 1; s <= QBITS; s++)
            begin
                vs_reg[s] <= vs_reg[s-1];
            end
            out_valid_reg <= vs_reg[QBITS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < N_ELEM; k++)
            begin
                amag_reg[k] <= in_item.cof[k][WIDE_W-1] ? '0 - in_item.cof[k] : in_item.cof[k];
                neg0_reg[k] <= in_item.cof[k][WIDE_W-1] ^ in_item.det[WIDE_W-1];
            end
            dmag_reg  <= in_item.det[WIDE_W-1] ? '0 - in_item.det : in_item.det;
            sing0_reg <= (in_item.det == '0);
            det0_reg  <= in_item.det[DET_W-1:0];

            sing_reg[0] <= sing0_reg;
            det_reg[0]  <= det0_reg;
            for (int s = 1; s <= QBITS; s++)
            begin
                sing_reg[s] <= sing_reg[s-1];
                det_reg[s]  <= det_reg[s-1];
            end
            for (int s = 0; s <= QBITS; s++)
            begin
                for (int k = 0; k < N_ELEM; k++)
                begin
                    ln_reg[s][k] <= ln_next[s][k];
                end
            end
            for (int k = 0; k < N_ELEM; k++)
            begin
                inv_reg[k] <= inv_next[k];
            end
            det_out_reg  <= det_reg[QBITS];
            sing_out_reg <= sing_reg[QBITS];
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.inv00       = inv_reg[0];
    assign out_ch.inv01       = inv_reg[1];
    assign out_ch.inv02       = inv_reg[2];
    assign out_ch.inv10       = inv_reg[3];
    assign out_ch.inv11       = inv_reg[4];
    assign out_ch.inv12       = inv_reg[5];
    assign out_ch.inv20       = inv_reg[6];
    assign out_ch.inv21       = inv_reg[7];
    assign out_ch.inv22       = inv_reg[8];
    assign out_ch.determinant = det_out_reg;
    assign out_ch.singular    = sing_out_reg;

endmodule

// File: rtl/core/matrix3x3_inverse_core.sv
// matrix3x3_inverse_core: top level of the 3x3 adjugate inverse core.
// Depends on mi3_pkg, mi3_if, mi3_front, mi3_queue, mi3_back.
//
// Usage:
//   in_ch  carries one matrix per item: a00..a22, signed, 12 fraction bits.
//   out_ch carries one result per item: inv00..inv22 in signed Q16.16
//          (saturated), the low 52 bits of the determinant, and singular,
//          which is set with all inverse elements zero when det is zero.
//   Throughput is one item per clock while out_ch.ready stays high.
//   From acceptance to out_ch.valid an item passes 4 front stages
//   (products, cofactors, determinant partials, determinant sum), the
//   queue register, then a magnitude stage, a saturation/setup stage,
//   31 restoring divide stages (one quotient bit each) and the output register.
//   When out_ch.valid is high and out_ch.ready low the back half holds; the front
//   accepts until the queue fills and its last stage is full, then in_ch.ready drops.
//   rst_n clears all valid state asynchronously; no item is in flight after.
`timescale 1ns / 1ps

module matrix3x3_inverse_core import mi3_pkg::*; #(
    parameter int ELEM_WIDTH  = ELEM_WIDTH_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    mi3_in_if.sink    in_ch,
    mi3_out_if.source out_ch
);

    logic        f_valid, f_ready, b_valid, b_ready;
    front_item_t f_item, b_item;

    mi3_front #(
        .ELEM_WIDTH(ELEM_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_item  (f_item)
    );

    mi3_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_item   (f_item),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_item  (b_item)
    );

    mi3_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (b_valid),
        .in_ready (b_ready),
        .in_item  (b_item),
        .out_ch   (out_ch)
    );

endmodule

// File: rtl/core/mi3_checker.sv
// mi3_checker: port-level assertions for matrix3x3_inverse_core, bound to the top level.
// Depends on mi3_pkg.
`timescale 1ns / 1ps

module mi3_checker import mi3_pkg::*; (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic                    singular,
    input logic signed [INV_W-1:0] inv00,
    input logic signed [INV_W-1:0] inv11,
    input logic signed [INV_W-1:0] inv22,
    input logic signed [DET_W-1:0] determinant
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(determinant) && $stable(singular))
        else $error("result changed while stalled");

    a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && singular |-> inv00 == '0 && inv11 == '0 && inv22 == '0)
        else $error("singular item with nonzero inverse");

    a_sing_det: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && singular |-> determinant == '0)
        else $error("singular item with nonzero determinant");

    a_reset_idle: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result valid right after reset");

endmodule

bind matrix3x3_inverse_core mi3_checker u_mi3_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .singular    (out_ch.singular),
    .inv00       (out_ch.inv00),
    .inv11       (out_ch.inv11),
    .inv22       (out_ch.inv22),
    .determinant (out_ch.determinant)
);
